// ===== hw/rtl/indexed_insert_erase_array_assert.svh =====
// assertion macros for the indexed insert/erase array
// used by indexed_insert_erase_array.sv, no other dependencies
`ifndef INDEXED_INSERT_ERASE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_ERASE_ARRAY_ASSERT_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define IIEA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define IIEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IIEA_ASSERT(lbl, clk, rst_n, prop, msg)
`define IIEA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/iiea_pkg.sv =====
// shared types and constants of the indexed insert/erase array
// no dependencies
package iiea_pkg;

	localparam int FUNC_W      = 3;
	localparam int IDX_W       = 5;
	localparam int VAL_W       = 32;
	localparam int STAT_W      = 2;
	localparam int CNT_W       = 5;
	localparam int DEPTH_DEF   = 16;
	localparam int DATA_W_DEF  = 32;
	localparam int DEPTH_MAX   = 256;
	localparam int DATA_W_MAX  = 64;
	// position width covering 0 .. DEPTH_MAX
	localparam int CELL_POS_W  = $clog2(DEPTH_MAX + 1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_READ    = 3'd0,
		FUNC_INSERT  = 3'd1,
		FUNC_ERASE   = 3'd2,
		FUNC_REPLACE = 3'd3,
		FUNC_APPEND  = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what the row of cells does this cycle
	typedef enum logic [1:0] {
		CELL_NONE   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_ERASE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CELL_POS_W-1:0]  pos;
	} cell_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [IDX_W-1:0]   index;
		logic [VAL_W-1:0]   value;
	} req_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic [STAT_W-1:0]  status;
		logic [CNT_W-1:0]   count;
	} rsp_beat_t;

endpackage

// ===== hw/rtl/indexed_insert_erase_array.sv =====
// indexed insert/erase array: top level with control and the row of cells
// depends on iiea_pkg, iiea_cell and indexed_insert_erase_array_assert.svh
//
// Usage
//   req channel (req_valid/req_ready/req) carries one request beat: func,
//   index and value. rsp channel (rsp_valid/rsp_ready/rsp) returns one beat
//   per request: read_value, status and the entry count after the operation.
//   The list lives in a row of DEPTH cells. Insert and erase shift every
//   cell by one place in the same cycle, each cell loading from its neighbor.
//   The response is registered, valid in the cycle after acceptance.
//   Throughput: one request per cycle; the only limit is the response
//   register, which takes a new beat whenever it is empty or being drained.
//   When the receiver stalls, the response holds and req_ready drops until
//   it is taken, so at most one response waits.
//   Reset clears the entry count and the response valid; the cells are
//   not cleared and are never read before written. No clearing pass.
//   Counts above the range of the count field wrap.
module indexed_insert_erase_array #(
	parameter int DEPTH      = iiea_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iiea_pkg::DATA_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  iiea_pkg::req_beat_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output iiea_pkg::rsp_beat_t  rsp
);
	import iiea_pkg::*;

	`include "indexed_insert_erase_array_assert.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam logic [CELL_POS_W-1:0] DEPTH_X = CELL_POS_W'(DEPTH);

	logic                   req_fire;
	logic [CW-1:0]          used_q;
	logic [CW-1:0]          used_nx;
	logic [CELL_POS_W-1:0]  idx_x;
	logic [CELL_POS_W-1:0]  used_x;
	logic [DATA_W_MAX-1:0]  wr_ext;
	logic [DATA_WIDTH-1:0]  wr_data;
	logic [DATA_WIDTH-1:0]  rd_data;
	logic [DATA_W_MAX-1:0]  rd_ext;
	logic [STAT_W-1:0]      status;
	cell_op_t               op;
	cell_cmd_t              cmd;
	logic [CELL_POS_W-1:0]  used_nx_x;
	logic [DATA_WIDTH-1:0]  entries [DEPTH];
	rsp_beat_t              rsp_q;
	logic                   rsp_valid_q;

	assign req_fire = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;

	assign idx_x   = CELL_POS_W'(req.index);
	assign used_x  = CELL_POS_W'(used_q);
	assign wr_ext  = DATA_W_MAX'(req.value);
	assign wr_data = wr_ext[DATA_WIDTH-1:0];

	// decode the request and check index and capacity
	always_comb begin
		op      = CELL_NONE;
		cmd.pos = idx_x;
		status  = ST_OK;
		used_nx = used_q;
		rd_data = '0;
		case (func_t'(req.func))
			FUNC_READ: begin
				if (idx_x < used_x)
					rd_data = entries[idx_x[AW-1:0]];
				else
					status = ST_RANGE;
			end
			FUNC_INSERT: begin
				if (idx_x > used_x) begin
					status = ST_RANGE;
				end else if (used_x == DEPTH_X) begin
					status = ST_FULL;
				end else begin
					op      = CELL_INSERT;
					used_nx = used_q + CW'(1);
				end
			end
			FUNC_ERASE: begin
				if (idx_x < used_x) begin
					op      = CELL_ERASE;
					used_nx = used_q - CW'(1);
				end else begin
					status = ST_RANGE;
				end
			end
			FUNC_REPLACE: begin
				if (idx_x < used_x)
					op = CELL_WRITE;
				else
					status = ST_RANGE;
			end
			FUNC_APPEND: begin
				cmd.pos = used_x;
				if (used_x == DEPTH_X) begin
					status = ST_FULL;
				end else begin
					op      = CELL_WRITE;
					used_nx = used_q + CW'(1);
				end
			end
			default: op = CELL_NONE;
		endcase
		cmd.op = req_fire ? op : CELL_NONE;
	end

	// row of cells, each wired to its neighbors
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;

		if (k == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = entries[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = entries[k+1];
		end

		iiea_cell #(
			.POS        (k),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.wr_data (wr_data),
			.lower   (lower),
			.upper   (upper),
			.entry   (entries[k])
		);
	end

	assign rd_ext    = DATA_W_MAX'(rd_data);
	assign used_nx_x = CELL_POS_W'(used_nx);

	// entry count, response register and its valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				used_q      <= used_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q.read_value <= rd_ext[VAL_W-1:0];
			rsp_q.status     <= status;
			rsp_q.count      <= used_nx_x[CNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`IIEA_ASSERT(a_count_in_range, clk, arst_n, used_x <= DEPTH_X, "entry count above depth")
	`IIEA_ASSERT(a_insert_grows, clk, arst_n, req_fire && op == CELL_INSERT |=> used_q == $past(used_q) + CW'(1), "insert did not grow count")
	`IIEA_ASSERT(a_full_only_at_depth, clk, arst_n, req_fire && status == ST_FULL |-> used_x == DEPTH_X, "full status below depth")
	`IIEA_ASSERT(a_read_only_data, clk, arst_n, req_fire && func_t'(req.func) != FUNC_READ |=> rsp_q.read_value == '0, "nonzero read data on a non-read")
	`IIEA_ASSERT_ALWAYS(a_no_ready_when_stalled, clk, rsp_valid_q && !rsp_ready |-> !req_ready, "request taken while response stalled")

endmodule

// ===== hw/rtl/iiea_cell.sv =====
// one list slot: holds an entry, loads from its neighbors on insert/erase
// depends on iiea_pkg
module iiea_cell #(
	parameter int POS        = 0,
	parameter int DATA_WIDTH = iiea_pkg::DATA_W_DEF
) (
	input  logic                   clk,
	input  iiea_pkg::cell_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0]  wr_data,
	input  logic [DATA_WIDTH-1:0]  lower,
	input  logic [DATA_WIDTH-1:0]  upper,
	output logic [DATA_WIDTH-1:0]  entry
);
	import iiea_pkg::*;

	localparam logic [CELL_POS_W-1:0] MY_POS = CELL_POS_W'(POS);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_nx;

	// next entry from the broadcast command and this slot's place
	always_comb begin
		entry_nx = entry_q;
		case (cmd.op)
			CELL_WRITE: begin
				if (cmd.pos == MY_POS)
					entry_nx = wr_data;
			end
			CELL_INSERT: begin
				if (MY_POS > cmd.pos)
					entry_nx = lower;
				else if (MY_POS == cmd.pos)
					entry_nx = wr_data;
			end
			CELL_ERASE: begin
				if (MY_POS >= cmd.pos)
					entry_nx = upper;
			end
			default: entry_nx = entry_q;
		endcase
	end

	// entry storage, no reset
	always_ff @(posedge clk) begin
		entry_q <= entry_nx;
	end

	assign entry = entry_q;

endmodule
